>>> src/assert_macros.svh
// Assertion macros for the port-level checker module.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ate_pkg.sv
// Shared types, character codes and helper functions of the terminal command encoder.
// No dependencies; used by ate_front, ate_queue, ate_back and the top level.
package ate_pkg;

  // Command codes on in_cmd
  typedef enum logic [3:0] {
    CMD_MOVE     = 4'd0,
    CMD_EOL      = 4'd1,
    CMD_EOP      = 4'd2,
    CMD_BEEP     = 4'd3,
    CMD_INSERT   = 4'd4,
    CMD_DELETE   = 4'd5,
    CMD_WINDOW   = 4'd6,
    CMD_NOWINDOW = 4'd7,
    CMD_COLOR    = 4'd8
  } cmd_t;

  // Character codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UH    = 8'h48;  // 'H'
  localparam logic [7:0] CH_UJ    = 8'h4A;  // 'J'
  localparam logic [7:0] CH_UK    = 8'h4B;  // 'K'
  localparam logic [7:0] CH_UM    = 8'h4D;  // 'M'
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_LM    = 8'h6D;  // 'm'
  localparam logic [7:0] CH_LR    = 8'h72;  // 'r'
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int COORD_W = 8;
  localparam int CNT_W   = 5;

  // Fixed byte strings that close a job, possibly repeated
  typedef enum logic [3:0] {
    TK_NONE    = 4'd0,
    TK_EOL     = 4'd1,
    TK_EOP     = 4'd2,
    TK_BEL     = 4'd3,
    TK_NOWIN   = 4'd4,
    TK_NORMAL  = 4'd5,
    TK_REVERSE = 4'd6,
    TK_INS     = 4'd7,
    TK_DEL     = 4'd8,
    TK_ERR     = 4'd9
  } tail_kind_t;

  // One job for the back end: optional region set, optional move, then a tail
  typedef struct packed {
    logic                 win_en;
    logic [COORD_W-1:0]   win_t;
    logic [COORD_W-1:0]   win_b;
    logic                 mov_en;
    logic [COORD_W-1:0]   mov_r;
    logic [COORD_W-1:0]   mov_c;
    tail_kind_t           tail;
    logic [CNT_W-1:0]     rep;
  } job_t;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Decimal digits of v + 1 (at most 256)
  function automatic digits_t to_dec(input logic [COORD_W-1:0] v);
    logic [8:0]  p;
    logic [6:0]  rem;
    logic [14:0] prod;
    digits_t     d;
    p = {1'b0, v} + 9'd1;
    if (p >= 9'd200) begin
      d.hund = 2'd2;
      rem    = 7'(p - 9'd200);
    end else if (p >= 9'd100) begin
      d.hund = 2'd1;
      rem    = 7'(p - 9'd100);
    end else begin
      d.hund = 2'd0;
      rem    = p[6:0];
    end
    // divide by ten through the reciprocal 205/2048, exact below 100
    prod   = 15'(rem) * 15'd205;
    d.tens = 4'(prod >> 11);
    d.ones = 4'(rem - 7'(d.tens) * 7'd10);
    return d;
  endfunction

  // Position of the leading digit of v + 1: 0 hundreds, 1 tens, 2 ones
  function automatic logic [1:0] first_pos(input logic [COORD_W-1:0] v);
    logic [8:0] p;
    p = {1'b0, v} + 9'd1;
    if (p >= 9'd100) return 2'd0;
    else if (p >= 9'd10) return 2'd1;
    else return 2'd2;
  endfunction

  // Byte idx of a tail string
  function automatic logic [7:0] tail_byte(input tail_kind_t k, input logic [1:0] idx);
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] s3;
    s0 = CH_ESC;
    s1 = CH_LBRK;
    s2 = CH_NUL;
    s3 = CH_NUL;
    case (k)
      TK_EOL:     s2 = CH_UK;
      TK_EOP:     s2 = CH_UJ;
      TK_BEL:     s0 = CH_BEL;
      TK_NOWIN: begin
        s2 = CH_SEMI;
        s3 = CH_LR;
      end
      TK_NORMAL:  s2 = CH_LM;
      TK_REVERSE: begin
        s2 = CH_SEVEN;
        s3 = CH_LM;
      end
      TK_INS:     s1 = CH_UM;
      TK_DEL:     s0 = CH_LF;
      default:    s0 = CH_NUL;
    endcase
    case (idx)
      2'd0:    return s0;
      2'd1:    return s1;
      2'd2:    return s2;
      default: return s3;
    endcase
  endfunction

  // Index of the final byte of a tail string
  function automatic logic [1:0] tail_last_idx(input tail_kind_t k);
    case (k)
      TK_EOL, TK_EOP, TK_NORMAL: return 2'd2;
      TK_NOWIN, TK_REVERSE:      return 2'd3;
      TK_INS:                    return 2'd1;
      default:                   return 2'd0;
    endcase
  endfunction

endpackage

>>> src/ate_front.sv
// Front end: accepts commands, keeps the cursor/region/color cache, builds jobs.
// Depends on ate_pkg; feeds ate_queue.
module ate_front #(
  parameter int MAX_LINES  = 16,
  parameter int COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            in_cmd,
  input  logic [7:0]            in_row,
  input  logic [7:0]            in_col,
  input  logic [7:0]            in_bottom,
  input  logic [4:0]            in_count,
  input  logic [1:0]            in_color,
  input  logic                  q_full,
  output logic                  push,
  output ate_pkg::job_t         job
);
  import ate_pkg::*;

  logic [COORD_BITS-1:0] crow_r, crow_nxt;
  logic [COORD_BITS-1:0] ccol_r, ccol_nxt;
  logic                  ck_r, ck_nxt;
  logic [COORD_BITS-1:0] wt_r, wt_nxt;
  logic [COORD_BITS-1:0] wb_r, wb_nxt;
  logic                  wk_r, wk_nxt;
  logic [1:0]            hue_r, hue_nxt;
  logic                  hk_r, hk_nxt;

  logic [COORD_BITS-1:0] r;
  logic [COORD_BITS-1:0] c;
  logic [COORD_BITS-1:0] b;
  logic [COORD_BITS-1:0] tgt;
  logic                  accept;
  logic                  win_chg;
  logic                  ck_eff;

  assign r        = in_row[COORD_BITS-1:0];
  assign c        = in_col[COORD_BITS-1:0];
  assign b        = in_bottom[COORD_BITS-1:0];
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign win_chg  = !wk_r || (r != wt_r) || (b != wb_r);
  assign ck_eff   = ck_r && !win_chg;
  assign tgt      = (in_cmd == CMD_INSERT) ? r : b;

  // classify the command against the cache
  always_comb begin
    job      = '0;
    crow_nxt = crow_r;
    ccol_nxt = ccol_r;
    ck_nxt   = ck_r;
    wt_nxt   = wt_r;
    wb_nxt   = wb_r;
    wk_nxt   = wk_r;
    hue_nxt  = hue_r;
    hk_nxt   = hk_r;
    case (in_cmd)
      CMD_MOVE: begin
        if (!ck_r || (r != crow_r) || (c != ccol_r)) begin
          job.mov_en = 1'b1;
          job.mov_r  = COORD_W'(r);
          job.mov_c  = COORD_W'(c);
          crow_nxt   = r;
          ccol_nxt   = c;
          ck_nxt     = 1'b1;
        end
      end
      CMD_EOL: begin
        job.tail = TK_EOL;
        job.rep  = 5'd1;
      end
      CMD_EOP: begin
        job.tail = TK_EOP;
        job.rep  = 5'd1;
      end
      CMD_BEEP: begin
        job.tail = TK_BEL;
        job.rep  = 5'd1;
      end
      CMD_INSERT, CMD_DELETE: begin
        if ((in_count > 5'(MAX_LINES)) || ((r == b) && (in_count != 5'd1))) begin
          job.tail = TK_ERR;
          job.rep  = 5'd1;
        end else if (r == b) begin
          // single line: home to column 0 and erase it
          if (!ck_r || (r != crow_r) || (ccol_r != '0)) begin
            job.mov_en = 1'b1;
            job.mov_r  = COORD_W'(r);
            crow_nxt   = r;
            ccol_nxt   = '0;
            ck_nxt     = 1'b1;
          end
          job.tail = TK_EOL;
          job.rep  = 5'd1;
        end else begin
          if (win_chg) begin
            job.win_en = 1'b1;
            job.win_t  = COORD_W'(r);
            job.win_b  = COORD_W'(b);
            wt_nxt     = r;
            wb_nxt     = b;
            wk_nxt     = 1'b1;
          end
          if (!ck_eff || (tgt != crow_r) || (ccol_r != '0)) begin
            job.mov_en = 1'b1;
            job.mov_r  = COORD_W'(tgt);
            crow_nxt   = tgt;
            ccol_nxt   = '0;
            ck_nxt     = 1'b1;
          end
          job.tail = (in_cmd == CMD_INSERT) ? TK_INS : TK_DEL;
          job.rep  = in_count;
        end
      end
      CMD_WINDOW: begin
        if (win_chg) begin
          job.win_en = 1'b1;
          job.win_t  = COORD_W'(r);
          job.win_b  = COORD_W'(b);
          wt_nxt     = r;
          wb_nxt     = b;
          wk_nxt     = 1'b1;
          ck_nxt     = 1'b0;
        end
      end
      CMD_NOWINDOW: begin
        job.tail = TK_NOWIN;
        job.rep  = 5'd1;
        ck_nxt   = 1'b0;
        wk_nxt   = 1'b0;
      end
      CMD_COLOR: begin
        if (!hk_r || (in_color != hue_r)) begin
          if (in_color == 2'd0) begin
            job.tail = TK_NORMAL;
            job.rep  = 5'd1;
          end else if (in_color == 2'd1) begin
            job.tail = TK_REVERSE;
            job.rep  = 5'd1;
          end
          hue_nxt = in_color;
          hk_nxt  = 1'b1;
        end
      end
      default: job = '0;
    endcase
  end

  // only jobs that send at least one byte go to the queue
  assign push = accept && (job.win_en || job.mov_en || (job.rep != '0));

  // cache registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crow_r <= '0;
      ccol_r <= '0;
      ck_r   <= 1'b0;
      wt_r   <= '0;
      wb_r   <= '0;
      wk_r   <= 1'b0;
      hue_r  <= 2'd0;
      hk_r   <= 1'b0;
    end else if (accept) begin
      crow_r <= crow_nxt;
      ccol_r <= ccol_nxt;
      ck_r   <= ck_nxt;
      wt_r   <= wt_nxt;
      wb_r   <= wb_nxt;
      wk_r   <= wk_nxt;
      hue_r  <= hue_nxt;
      hk_r   <= hk_nxt;
    end
  end

endmodule

>>> src/ate_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on ate_pkg for the job type.
module ate_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ate_pkg::job_t push_job,
  input  logic          pop,
  output ate_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import ate_pkg::*;

  localparam int DEPTH = 2;

  job_t       slot_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'(DEPTH));
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> src/ate_back.sv
// Back end: expands one job into escape bytes, one output word per cycle while out_stall is low.
// Depends on ate_pkg; takes jobs from ate_queue.
module ate_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ate_pkg::job_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_flush,
  output logic          out_error
);
  import ate_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_WIN, PH_MOV, PH_TAIL} phase_t;
  typedef enum logic [2:0] {PS_ESC, PS_LB, PS_A, PS_SEMI, PS_B, PS_TERM} pstep_t;

  phase_t       phase_r;
  pstep_t       pstep_r;
  job_t         job_r;
  logic [1:0]   dpos_r;
  logic [1:0]   tidx_r;
  logic [4:0]   rep_r;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  logic         out_last_r;
  logic         out_flush_r;
  logic         out_error_r;

  logic [7:0]   pa;
  logic [7:0]   pb;
  logic [7:0]   dig_v;
  digits_t      dd;
  logic [3:0]   digit;
  logic [7:0]   pair_b;
  logic [7:0]   cur_byte;
  logic         seg_end;
  logic         tail_wrap;
  phase_t       next_seg;
  phase_t       first_seg;
  logic         is_last;
  logic         can_emit;
  logic         load;

  assign can_emit = !out_valid_r || !out_stall;
  assign load     = (phase_r == PH_IDLE) && !q_empty;
  assign pop      = load;

  // byte of the current step
  always_comb begin
    pa    = (phase_r == PH_WIN) ? job_r.win_t : job_r.mov_r;
    pb    = (phase_r == PH_WIN) ? job_r.win_b : job_r.mov_c;
    dig_v = (pstep_r == PS_A) ? pa : pb;
    dd    = to_dec(dig_v);
    case (dpos_r)
      2'd0:    digit = {2'b00, dd.hund};
      2'd1:    digit = dd.tens;
      default: digit = dd.ones;
    endcase
    case (pstep_r)
      PS_ESC:        pair_b = CH_ESC;
      PS_LB:         pair_b = CH_LBRK;
      PS_A, PS_B:    pair_b = CH_ZERO + 8'(digit);
      PS_SEMI:       pair_b = CH_SEMI;
      default:       pair_b = (phase_r == PH_WIN) ? CH_LR : CH_UH;
    endcase
    tail_wrap = (tidx_r == tail_last_idx(job_r.tail));
    if (phase_r == PH_TAIL) begin
      cur_byte = tail_byte(job_r.tail, tidx_r);
      seg_end  = tail_wrap && (rep_r == 5'd1);
    end else begin
      cur_byte = pair_b;
      seg_end  = (pstep_r == PS_TERM);
    end
    case (phase_r)
      PH_WIN: begin
        if (job_r.mov_en)          next_seg = PH_MOV;
        else if (job_r.rep != '0)  next_seg = PH_TAIL;
        else                       next_seg = PH_IDLE;
      end
      PH_MOV:  next_seg = (job_r.rep != '0) ? PH_TAIL : PH_IDLE;
      default: next_seg = PH_IDLE;
    endcase
    is_last = seg_end && (next_seg == PH_IDLE);
    if (head.win_en)      first_seg = PH_WIN;
    else if (head.mov_en) first_seg = PH_MOV;
    else                  first_seg = PH_TAIL;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pstep_r     <= PS_ESC;
      out_valid_r <= 1'b0;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
          if (load) begin
            job_r   <= head;
            phase_r <= first_seg;
            pstep_r <= PS_ESC;
            tidx_r  <= 2'd0;
            rep_r   <= head.rep;
          end
        end
        default: begin
          if (can_emit) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= cur_byte;
            out_last_r  <= is_last;
            out_flush_r <= (phase_r == PH_TAIL) && (job_r.tail == TK_BEL);
            out_error_r <= (phase_r == PH_TAIL) && (job_r.tail == TK_ERR);
            if (seg_end) begin
              phase_r <= next_seg;
              pstep_r <= PS_ESC;
              tidx_r  <= 2'd0;
            end else if (phase_r == PH_TAIL) begin
              if (tail_wrap) begin
                tidx_r <= 2'd0;
                rep_r  <= rep_r - 5'd1;
              end else begin
                tidx_r <= tidx_r + 2'd1;
              end
            end else begin
              case (pstep_r)
                PS_ESC: pstep_r <= PS_LB;
                PS_LB: begin
                  pstep_r <= PS_A;
                  dpos_r  <= first_pos(pa);
                end
                PS_A: begin
                  if (dpos_r == 2'd2) pstep_r <= PS_SEMI;
                  else                dpos_r  <= dpos_r + 2'd1;
                end
                PS_SEMI: begin
                  pstep_r <= PS_B;
                  dpos_r  <= first_pos(pb);
                end
                PS_B: begin
                  if (dpos_r == 2'd2) pstep_r <= PS_TERM;
                  else                dpos_r  <= dpos_r + 2'd1;
                end
                default: pstep_r <= PS_ESC;
              endcase
            end
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_flush = out_flush_r;
  assign out_error = out_error_r;

endmodule

>>> src/ansi_terminal_command_encoder.sv
// Top level of the ANSI terminal command encoder.
// Instantiates ate_front, ate_queue and ate_back; depends on ate_pkg.

// Takes one display command per input word and answers with the ANSI escape
// bytes that carry it out, one byte per output word, out_last marking the end
// of a command. Cursor, scroll region and color are cached, so a command that
// changes nothing sends nothing; a rejected insert or delete gives a single
// word with out_error set. The back-end byte sequencer sets the pace: it loads
// a command from the job queue only when idle, then sends its bytes, holding a
// word while out_stall is high; a command that sends nothing stays in the front
// end. The front end takes new commands while the two-entry job queue has room,
// so up to two commands can wait behind the one whose bytes are being sent.
module ansi_terminal_command_encoder #(
  parameter int MAX_LINES  = 16,
  parameter int COORD_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_cmd,
  input  logic [7:0] in_row,
  input  logic [7:0] in_col,
  input  logic [7:0] in_bottom,
  input  logic [4:0] in_count,
  input  logic [1:0] in_color,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_flush,
  output logic       out_error
);
  import ate_pkg::*;

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  // command classification and cache
  ate_front #(
    .MAX_LINES  (MAX_LINES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_bottom (in_bottom),
    .in_count  (in_count),
    .in_color  (in_color),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  // job queue
  ate_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // byte generation
  ate_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_flush (out_flush),
    .out_error (out_error)
  );

endmodule

>>> src/ate_checker.sv
// Port-level checker for the terminal command encoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ate_port_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_flush,
  input logic       out_error
);

  // a rejected command is one word, zero byte, no flush
  `ASSERT_IMPLIES(a_err_word, out_valid && out_error,
    out_last && (out_byte == 8'h00) && !out_flush, "error word malformed")

  // flush only comes with the lone BEL byte
  `ASSERT_IMPLIES(a_flush_bel, out_valid && out_flush,
    out_last && (out_byte == 8'h07) && !out_error, "flush without BEL")

  // bytes of one command leave back to back
  `ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !out_last, out_valid, "gap inside a sequence")

  // a stalled word holds
  `ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(out_last), "stalled word changed")

endmodule

bind ansi_terminal_command_encoder ate_port_chk u_chk (.*);

>>> tb/sv/ate_checker.sv
// Checker for the ANSI terminal command encoder: predicts the escape bytes of each accepted
// command word and compares every accepted output word against them, in order.
// Depends on ate_pkg for command codes and character codes.
module ate_checker #(
  parameter int MAX_LINES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] in_cmd,
  input  logic [7:0] in_row,
  input  logic [7:0] in_col,
  input  logic [7:0] in_bottom,
  input  logic [4:0] in_count,
  input  logic [1:0] in_color,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       out_flush,
  input  logic       out_error,
  output int         fail_count,
  output int         words_due
);
  import ate_pkg::*;

  localparam logic [1:0] HUE_NORMAL  = 2'd0;
  localparam logic [1:0] HUE_REVERSE = 2'd1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       flush;
    logic       err;
  } enc_word_t;

  // expected output words, oldest first
  enc_word_t  esc_words_q[$];
  // bytes of the command being predicted
  logic [7:0] seq_ch[$];
  logic       seq_fl[$];

  // cached terminal state
  logic [7:0] cur_row;
  logic [7:0] cur_col;
  logic       cur_known;
  logic [7:0] win_top;
  logic [7:0] win_bot;
  logic       win_known;
  logic [1:0] cur_hue;
  logic       hue_known;

  task automatic emit(input logic [7:0] b, input logic fl);
    seq_ch.push_back(b);
    seq_fl.push_back(fl);
  endtask

  // decimal ASCII of v + 1, no leading zeros
  task automatic emit_dec(input logic [7:0] v);
    int p;
    p = int'(v) + 1;
    if (p >= 100) emit(CH_ZERO + 8'((p / 100) % 10), 1'b0);
    if (p >= 10) emit(CH_ZERO + 8'((p / 10) % 10), 1'b0);
    emit(CH_ZERO + 8'(p % 10), 1'b0);
  endtask

  task automatic emit_move(input logic [7:0] r, input logic [7:0] c);
    if (!cur_known || r != cur_row || c != cur_col) begin
      emit(CH_ESC, 1'b0);
      emit(CH_LBRK, 1'b0);
      emit_dec(r);
      emit(CH_SEMI, 1'b0);
      emit_dec(c);
      emit(CH_UH, 1'b0);
      cur_row   = r;
      cur_col   = c;
      cur_known = 1'b1;
    end
  endtask

  task automatic emit_window(input logic [7:0] t, input logic [7:0] b);
    if (!win_known || t != win_top || b != win_bot) begin
      emit(CH_ESC, 1'b0);
      emit(CH_LBRK, 1'b0);
      emit_dec(t);
      emit(CH_SEMI, 1'b0);
      emit_dec(b);
      emit(CH_LR, 1'b0);
      cur_known = 1'b0;
      win_top   = t;
      win_bot   = b;
      win_known = 1'b1;
    end
  endtask

  task automatic emit_eol();
    emit(CH_ESC, 1'b0);
    emit(CH_LBRK, 1'b0);
    emit(CH_UK, 1'b0);
  endtask

  // insert (scroll back at top) or delete (line feeds at bottom); ok low on reject
  task automatic emit_lines(input logic ins, input logic [7:0] r, input logic [7:0] b,
                            input logic [4:0] n, output logic ok);
    int i;
    ok = 1'b1;
    if (int'(n) > MAX_LINES) begin
      ok = 1'b0;
    end else if (r == b) begin
      // single line: only a count of one is allowed
      if (n != 5'd1) begin
        ok = 1'b0;
      end else begin
        emit_move(r, 8'd0);
        emit_eol();
      end
    end else begin
      emit_window(r, b);
      emit_move(ins ? r : b, 8'd0);
      for (i = 0; i < int'(n); i++) begin
        if (ins) begin
          emit(CH_ESC, 1'b0);
          emit(CH_UM, 1'b0);
        end else begin
          emit(CH_LF, 1'b0);
        end
      end
    end
  endtask

  // expected words for one command word
  task automatic predict_escape(input logic [3:0] cmd, input logic [7:0] r,
                                input logic [7:0] c, input logic [7:0] b,
                                input logic [4:0] n, input logic [1:0] hue);
    logic ok;
    int   k;
    ok = 1'b1;
    seq_ch.delete();
    seq_fl.delete();
    case (cmd)
      CMD_MOVE:   emit_move(r, c);
      CMD_EOL:    emit_eol();
      CMD_EOP: begin
        emit(CH_ESC, 1'b0);
        emit(CH_LBRK, 1'b0);
        emit(CH_UJ, 1'b0);
      end
      CMD_BEEP:   emit(CH_BEL, 1'b1);
      CMD_INSERT: emit_lines(1'b1, r, b, n, ok);
      CMD_DELETE: emit_lines(1'b0, r, b, n, ok);
      CMD_WINDOW: emit_window(r, b);
      CMD_NOWINDOW: begin
        emit(CH_ESC, 1'b0);
        emit(CH_LBRK, 1'b0);
        emit(CH_SEMI, 1'b0);
        emit(CH_LR, 1'b0);
        cur_known = 1'b0;
        win_known = 1'b0;
      end
      CMD_COLOR: begin
        if (!hue_known || hue != cur_hue) begin
          if (hue == HUE_NORMAL) begin
            emit(CH_ESC, 1'b0);
            emit(CH_LBRK, 1'b0);
            emit(CH_LM, 1'b0);
          end else if (hue == HUE_REVERSE) begin
            emit(CH_ESC, 1'b0);
            emit(CH_LBRK, 1'b0);
            emit(CH_SEVEN, 1'b0);
            emit(CH_LM, 1'b0);
          end
          cur_hue   = hue;
          hue_known = 1'b1;
        end
      end
      default: ;
    endcase
    if (!ok) begin
      esc_words_q.push_back('{ch: CH_NUL, last: 1'b1, flush: 1'b0, err: 1'b1});
    end else begin
      for (k = 0; k < seq_ch.size(); k++) begin
        esc_words_q.push_back('{ch: seq_ch[k], last: (k == seq_ch.size() - 1),
                                flush: seq_fl[k], err: 1'b0});
      end
    end
  endtask

  task automatic check_word();
    enc_word_t want;
    if (esc_words_q.size() == 0) begin
      $error("out_byte: no word expected, got %02h", out_byte);
      fail_count = fail_count + 1;
    end else begin
      want = esc_words_q.pop_front();
      if (out_byte !== want.ch) begin
        $error("out_byte: expected %02h, got %02h", want.ch, out_byte);
        fail_count = fail_count + 1;
      end
      if (out_last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, out_last);
        fail_count = fail_count + 1;
      end
      if (out_flush !== want.flush) begin
        $error("out_flush: expected %0b, got %0b", want.flush, out_flush);
        fail_count = fail_count + 1;
      end
      if (out_error !== want.err) begin
        $error("out_error: expected %0b, got %0b", want.err, out_error);
        fail_count = fail_count + 1;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  // watch both channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      esc_words_q.delete();
      cur_row   = 8'd0;
      cur_col   = 8'd0;
      cur_known = 1'b0;
      win_top   = 8'd0;
      win_bot   = 8'd0;
      win_known = 1'b0;
      cur_hue   = HUE_NORMAL;
      hue_known = 1'b0;
    end else begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall)
        predict_escape(in_cmd, in_row, in_col, in_bottom, in_count, in_color);
    end
    words_due = esc_words_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the terminal command encoder testbench: clock, reset, command stimulus,
// output stall pattern and the verdict. Depends on ate_pkg, ate_checker and the block.
module tb_top;
  import ate_pkg::*;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam int RANDOM_CMDS  = 95;
  localparam int QUIET_CMDS   = 20;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 200;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_cmd;
  logic [7:0] in_row;
  logic [7:0] in_col;
  logic [7:0] in_bottom;
  logic [4:0] in_count;
  logic [1:0] in_color;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_flush;
  logic       out_error;
  int         fail_count;
  int         words_due;

  // idling controls shared by the sender and receiver processes
  logic tx_gaps;
  logic rx_gaps;
  logic hold_req;

  ansi_terminal_command_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_bottom (in_bottom),
    .in_count  (in_count),
    .in_color  (in_color),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_flush (out_flush),
    .out_error (out_error)
  );

  ate_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_bottom  (in_bottom),
    .in_count   (in_count),
    .in_color   (in_color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_flush  (out_flush),
    .out_error  (out_error),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one command word and hold it until accepted, then maybe idle
  task automatic send_cmd(input logic [3:0] cmd, input logic [7:0] r, input logic [7:0] c,
                          input logic [7:0] b, input logic [4:0] n, input logic [1:0] hue);
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_row    <= r;
    in_col    <= c;
    in_bottom <= b;
    in_count  <= n;
    in_color  <= hue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // mostly small coordinates so the cursor, region and color caches get hits
  function automatic logic [7:0] pick_coord();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // one random command; counted is low for unused codes the block ignores
  task automatic send_random(output logic counted);
    int         pick;
    int         sel;
    logic [3:0] cmd;
    logic [7:0] r;
    logic [7:0] b;
    logic [4:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 20)      cmd = CMD_MOVE;
    else if (pick < 26) cmd = CMD_EOL;
    else if (pick < 31) cmd = CMD_EOP;
    else if (pick < 36) cmd = CMD_BEEP;
    else if (pick < 54) cmd = CMD_INSERT;
    else if (pick < 72) cmd = CMD_DELETE;
    else if (pick < 82) cmd = CMD_WINDOW;
    else if (pick < 87) cmd = CMD_NOWINDOW;
    else if (pick < 96) cmd = CMD_COLOR;
    else cmd = 4'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)));
    counted = (pick < 96);
    r = pick_coord();
    b = ($urandom_range(0, 4) == 0) ? r : pick_coord();
    // line counts: mostly short, some at the limit, a few over it
    sel = $urandom_range(0, 9);
    if (sel < 6)       n = 5'($urandom_range(0, 4));
    else if (sel < 8)  n = 5'd16;
    else if (sel == 8) n = 5'($urandom_range(17, 31));
    else               n = 5'd1;
    send_cmd(cmd, r, pick_coord(), b, n, 2'($urandom_range(0, 3)));
  endtask

  // receiver: short random stalls, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_gaps && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int   h;
    int   n_sent;
    logic counted;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_cmd    <= CMD_MOVE;
    in_row    <= 8'd0;
    in_col    <= 8'd0;
    in_bottom <= 8'd0;
    in_count  <= 5'd0;
    in_color  <= 2'd0;
    tx_gaps   = 1'b1;
    rx_gaps   = 1'b1;
    hold_req  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cursor cache, widest coordinates, digit counts
    send_cmd(CMD_MOVE, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_MOVE, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_MOVE, 8'd255, 8'd255, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_MOVE, 8'd9, 8'd99, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_EOL, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_EOP, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_BEEP, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    // color from unknown, repeated, reverse, and the silent values
    send_cmd(CMD_COLOR, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    for (h = 0; h < 4; h++) send_cmd(CMD_COLOR, 8'd0, 8'd0, 8'd0, 5'd0, 2'(h));
    // region set, repeated, cleared
    send_cmd(CMD_WINDOW, 8'd0, 8'd0, 8'd255, 5'd0, 2'd0);
    send_cmd(CMD_WINDOW, 8'd0, 8'd0, 8'd255, 5'd0, 2'd0);
    send_cmd(CMD_NOWINDOW, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    // line insert/delete: normal, zero count, single line, rejects, top below bottom
    send_cmd(CMD_INSERT, 8'd2, 8'd0, 8'd10, 5'd3, 2'd0);
    send_cmd(CMD_DELETE, 8'd2, 8'd0, 8'd10, 5'd0, 2'd0);
    send_cmd(CMD_INSERT, 8'd5, 8'd0, 8'd5, 5'd1, 2'd0);
    send_cmd(CMD_DELETE, 8'd5, 8'd0, 8'd5, 5'd2, 2'd0);
    send_cmd(CMD_INSERT, 8'd1, 8'd0, 8'd4, 5'd17, 2'd0);
    send_cmd(CMD_DELETE, 8'd1, 8'd0, 8'd4, 5'd31, 2'd0);
    send_cmd(CMD_INSERT, 8'd10, 8'd0, 8'd3, 5'd16, 2'd0);
    send_cmd(CMD_DELETE, 8'd0, 8'd0, 8'd255, 5'd16, 2'd0);
    // unused codes, all other fields at both extremes
    send_cmd(CMD_UNUSED_LO, 8'd0, 8'd0, 8'd0, 5'd0, 2'd0);
    send_cmd(CMD_UNUSED_HI, 8'd255, 8'd255, 8'd255, 5'd31, 2'd3);

    // random: starts under a long output hold-off so the block backs up
    hold_req = 1'b1;
    n_sent   = 0;
    while (n_sent < RANDOM_CMDS) begin
      if (n_sent == RANDOM_CMDS - QUIET_CMDS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      send_random(counted);
      if (counted) n_sent++;
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // drain, then allow for trailing silent commands
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("ansi_terminal_command_encoder: match");
    end else begin
      $display("ansi_terminal_command_encoder: mismatch");
    end
    $finish;
  end

  // hard stop
  initial begin
    #3000000;
    $display("ansi_terminal_command_encoder: mismatch");
    $finish;
  end

endmodule
